// ===== hdl/chtir_pkg.sv =====
// Shared constants for the chained hash table engine.
package chtir_pkg;

    localparam int NODE_COUNT   = 1024;
    localparam int SLOT_W       = 10;
    localparam int LINK_W       = 11;
    localparam int MAX_BUCKETS  = 1024;
    localparam int BKT_W        = 10;
    localparam int INIT_BUCKETS = 8;
    localparam int INIT_LOG2    = 3;
    localparam int LOG2_W       = 4;
    localparam int KEY_BITS     = 32;
    localparam int HASH_W       = 64;
    localparam int CNT_W        = 11;

    localparam logic [LINK_W-1:0] EMPTY_LINK = LINK_W'(NODE_COUNT);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

endpackage

// ===== hdl/chained_hash_table_incremental_rehash.sv =====
// Hash table engine with chained buckets and incremental rehash, top level.
// A NOP, or a lookup or remove before allocation, goes straight to the response; otherwise
// the work of a request grows with each migrated node, skipped bucket and searched node.
// Allocation and the start of a rehash each add a clearing pass of 8 or 2N head entries.
// One request at a time: busy is high from acceptance until the done strobe.
// Asynchronous reset gives an unallocated, empty table; results cannot be stalled.
module chained_hash_table_incremental_rehash (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    opcode,
    input  logic [63:0]                   hash_code,
    input  logic [31:0]                   key_value,
    input  logic [9:0]                    node_slot,
    output logic                          done,
    output logic                          found,
    output logic [9:0]                    result_slot,
    output logic [10:0]                   entry_count,
    output logic                          rehash_active
);

    localparam int LW = chtir_pkg::LINK_W;
    localparam int BW = chtir_pkg::BKT_W;
    localparam int SW = chtir_pkg::SLOT_W;
    localparam int CW = chtir_pkg::CNT_W;
    localparam int KW = chtir_pkg::KEY_BITS;
    localparam int HW = chtir_pkg::HASH_W;
    localparam int GW = chtir_pkg::LOG2_W;

    typedef enum logic [4:0] {
        S_IDLE, S_CLR, S_MIG_RD, S_MIG_CHK, S_MV_RD, S_MV_HD, S_MV_WR, S_OP,
        S_INS_RD, S_INS_WR, S_INS_CHK, S_SR_HD, S_SR_HDW, S_SR_NRD, S_SR_CMP,
        S_SR_RM2, S_RESP
    } state_t;

    state_t            state_reg, clr_ret_reg;
    logic [1:0]        op_reg;
    logic [HW-1:0]     hash_reg;
    logic [KW-1:0]     key_reg;
    logic [SW-1:0]     slot_reg;
    logic              act_reg, mig_reg, tbl_reg;
    logic [GW-1:0]     log2_reg;
    logic [CW-1:0]     old_cnt_reg, new_cnt_reg;
    logic [BW:0]       mig_idx_reg;
    logic [LW-1:0]     cur_reg, prev_reg;
    logic [LW-1:0]     steps_reg;
    logic              clr_bank_reg;
    logic [BW:0]       clr_idx_reg, clr_len_reg;
    logic              found_reg, done_reg;
    logic [SW-1:0]     res_reg, out_slot_reg;
    logic              out_found_reg, out_mig_reg;
    logic [CW-1:0]     out_cnt_reg;

    // Storage: head banks side by side, node hash with key, node links.
    logic [LW-1:0]     heads_mem [2*chtir_pkg::MAX_BUCKETS];
    logic [HW+KW-1:0]  hk_mem    [chtir_pkg::NODE_COUNT];
    logic [LW-1:0]     link_mem  [chtir_pkg::NODE_COUNT];

    logic [LW-1:0]     hd_q, lk_q;
    logic [HW+KW-1:0]  hk_q;
    logic [BW:0]       hd_raddr, hd_waddr;
    logic              hd_we, lk_we, hk_we;
    logic [LW-1:0]     hd_wdata, lk_wdata;
    logic [SW-1:0]     lk_waddr;

    logic [BW:0]       old_nb, nb2;
    logic [BW:0]       new_mask, ins_mask, sr_mask;
    logic [GW-1:0]     ins_lg, sr_lg;
    logic              ins_bank, sr_bank;
    logic [BW-1:0]     mv_idx, ins_idx, sr_idx;
    logic [HW-1:0]     node_hash;
    logic [KW-1:0]     node_key;
    logic [CW:0]       total;

    function automatic logic [CW-1:0] cnt_up(input logic [CW-1:0] c);
        return (c < CW'(chtir_pkg::NODE_COUNT)) ? c + CW'(1) : c;
    endfunction

    function automatic logic [CW-1:0] cnt_down(input logic [CW-1:0] c);
        return (c != '0) ? c - CW'(1) : c;
    endfunction

    always_comb
    begin
        old_nb    = (BW+1)'(1) << log2_reg;
        nb2       = old_nb << 1;
        new_mask  = nb2 - (BW+1)'(1);
        ins_lg    = log2_reg + GW'(mig_reg);
        ins_bank  = act_reg ^ mig_reg;
        ins_mask  = ((BW+1)'(1) << ins_lg) - (BW+1)'(1);
        sr_lg     = log2_reg + GW'(tbl_reg);
        sr_bank   = act_reg ^ tbl_reg;
        sr_mask   = ((BW+1)'(1) << sr_lg) - (BW+1)'(1);
        node_hash = hk_q[HW+KW-1:KW];
        node_key  = hk_q[KW-1:0];
        mv_idx    = node_hash[BW-1:0] & new_mask[BW-1:0];
        ins_idx   = hash_reg[BW-1:0] & ins_mask[BW-1:0];
        sr_idx    = hash_reg[BW-1:0] & sr_mask[BW-1:0];
        total     = {1'b0, old_cnt_reg} + {1'b0, new_cnt_reg};
    end

    always_comb
    begin
        case (state_reg)
            S_MIG_RD: hd_raddr = {act_reg, mig_idx_reg[BW-1:0]};
            S_MV_HD:  hd_raddr = {~act_reg, mv_idx};
            S_INS_RD: hd_raddr = {ins_bank, ins_idx};
            default:  hd_raddr = {sr_bank, sr_idx};
        endcase
    end

    always_comb
    begin
        hd_we    = 1'b0;
        hd_waddr = {clr_bank_reg, clr_idx_reg[BW-1:0]};
        hd_wdata = chtir_pkg::EMPTY_LINK;
        lk_we    = 1'b0;
        lk_waddr = cur_reg[SW-1:0];
        lk_wdata = hd_q;
        hk_we    = 1'b0;
        case (state_reg)
            S_CLR:
            begin
                hd_we = 1'b1;
            end
            S_MIG_CHK:
            begin
                hd_we    = (hd_q != chtir_pkg::EMPTY_LINK);
                hd_waddr = {act_reg, mig_idx_reg[BW-1:0]};
            end
            S_MV_WR:
            begin
                hd_we    = 1'b1;
                hd_waddr = {~act_reg, mv_idx};
                hd_wdata = cur_reg;
                lk_we    = 1'b1;
            end
            S_INS_WR:
            begin
                hd_we    = 1'b1;
                hd_waddr = {ins_bank, ins_idx};
                hd_wdata = LW'(slot_reg);
                lk_we    = 1'b1;
                lk_waddr = slot_reg;
                hk_we    = 1'b1;
            end
            S_SR_CMP:
            begin
                if (op_reg == chtir_pkg::OP_REMOVE && node_hash == hash_reg
                    && node_key == key_reg)
                begin
                    if (prev_reg == chtir_pkg::EMPTY_LINK)
                    begin
                        hd_we    = 1'b1;
                        hd_waddr = {sr_bank, sr_idx};
                        hd_wdata = lk_q;
                    end
                    else
                    begin
                        lk_we    = 1'b1;
                        lk_waddr = prev_reg[SW-1:0];
                        lk_wdata = lk_q;
                    end
                end
            end
            S_SR_RM2:
            begin
                lk_we    = 1'b1;
                lk_wdata = chtir_pkg::EMPTY_LINK;
            end
            default:
            begin
                hd_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (hd_we)
            heads_mem[hd_waddr] <= hd_wdata;
        hd_q <= heads_mem[hd_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lk_we)
            link_mem[lk_waddr] <= lk_wdata;
        lk_q <= link_mem[cur_reg[SW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (hk_we)
            hk_mem[slot_reg] <= {hash_reg, key_reg};
        hk_q <= hk_mem[cur_reg[SW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            clr_ret_reg   <= S_IDLE;
            act_reg       <= 1'b0;
            mig_reg       <= 1'b0;
            tbl_reg       <= 1'b0;
            log2_reg      <= '0;
            old_cnt_reg   <= '0;
            new_cnt_reg   <= '0;
            mig_idx_reg   <= '0;
            done_reg      <= 1'b0;
            found_reg     <= 1'b0;
            res_reg       <= '0;
            out_found_reg <= 1'b0;
            out_slot_reg  <= '0;
            out_cnt_reg   <= '0;
            out_mig_reg   <= 1'b0;
            clr_bank_reg  <= 1'b0;
            clr_idx_reg   <= '0;
            clr_len_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg    <= opcode;
                        hash_reg  <= hash_code;
                        key_reg   <= key_value;
                        slot_reg  <= node_slot;
                        found_reg <= 1'b0;
                        res_reg   <= '0;
                        tbl_reg   <= 1'b0;
                        if (opcode == chtir_pkg::OP_INSERT && log2_reg == '0)
                        begin
                            log2_reg     <= GW'(chtir_pkg::INIT_LOG2);
                            old_cnt_reg  <= '0;
                            new_cnt_reg  <= '0;
                            mig_reg      <= 1'b0;
                            mig_idx_reg  <= '0;
                            clr_bank_reg <= act_reg;
                            clr_idx_reg  <= '0;
                            clr_len_reg  <= (BW+1)'(chtir_pkg::INIT_BUCKETS);
                            clr_ret_reg  <= S_OP;
                            state_reg    <= S_CLR;
                        end
                        else if (opcode == chtir_pkg::OP_INSERT
                                 || ((opcode == chtir_pkg::OP_LOOKUP
                                      || opcode == chtir_pkg::OP_REMOVE)
                                     && log2_reg != '0))
                            state_reg <= mig_reg ? S_MIG_RD : S_OP;
                        else
                            state_reg <= S_RESP;
                    end
                end
                S_CLR:
                begin
                    clr_idx_reg <= clr_idx_reg + (BW+1)'(1);
                    if (clr_idx_reg == clr_len_reg - (BW+1)'(1))
                        state_reg <= clr_ret_reg;
                end
                S_MIG_RD:
                begin
                    if (mig_idx_reg >= old_nb)
                    begin
                        // Old table drained: the new table takes over.
                        act_reg     <= ~act_reg;
                        log2_reg    <= log2_reg + GW'(1);
                        old_cnt_reg <= new_cnt_reg;
                        new_cnt_reg <= '0;
                        mig_reg     <= 1'b0;
                        mig_idx_reg <= '0;
                        state_reg   <= S_OP;
                    end
                    else
                        state_reg <= S_MIG_CHK;
                end
                S_MIG_CHK:
                begin
                    if (hd_q == chtir_pkg::EMPTY_LINK)
                    begin
                        mig_idx_reg <= mig_idx_reg + (BW+1)'(1);
                        state_reg   <= S_MIG_RD;
                    end
                    else
                    begin
                        cur_reg   <= hd_q;
                        steps_reg <= '0;
                        state_reg <= S_MV_RD;
                    end
                end
                S_MV_RD:
                begin
                    if (cur_reg >= chtir_pkg::EMPTY_LINK
                        || steps_reg >= LW'(chtir_pkg::NODE_COUNT))
                    begin
                        mig_idx_reg <= mig_idx_reg + (BW+1)'(1);
                        state_reg   <= S_OP;
                    end
                    else
                        state_reg <= S_MV_HD;
                end
                S_MV_HD:
                begin
                    state_reg <= S_MV_WR;
                end
                S_MV_WR:
                begin
                    old_cnt_reg <= cnt_down(old_cnt_reg);
                    new_cnt_reg <= cnt_up(new_cnt_reg);
                    cur_reg     <= lk_q;
                    steps_reg   <= steps_reg + LW'(1);
                    state_reg   <= S_MV_RD;
                end
                S_OP:
                begin
                    state_reg <= (op_reg == chtir_pkg::OP_INSERT) ? S_INS_RD : S_SR_HD;
                end
                S_INS_RD:
                begin
                    state_reg <= S_INS_WR;
                end
                S_INS_WR:
                begin
                    if (mig_reg)
                        new_cnt_reg <= cnt_up(new_cnt_reg);
                    else
                        old_cnt_reg <= cnt_up(old_cnt_reg);
                    found_reg <= 1'b1;
                    res_reg   <= slot_reg;
                    state_reg <= S_INS_CHK;
                end
                S_INS_CHK:
                begin
                    if (!mig_reg && old_cnt_reg > CW'(old_nb)
                        && nb2 <= (BW+1)'(chtir_pkg::MAX_BUCKETS))
                    begin
                        mig_reg      <= 1'b1;
                        mig_idx_reg  <= '0;
                        new_cnt_reg  <= '0;
                        clr_bank_reg <= ~act_reg;
                        clr_idx_reg  <= '0;
                        clr_len_reg  <= nb2;
                        clr_ret_reg  <= S_RESP;
                        state_reg    <= S_CLR;
                    end
                    else
                        state_reg <= S_RESP;
                end
                S_SR_HD:
                begin
                    state_reg <= S_SR_HDW;
                end
                S_SR_HDW:
                begin
                    cur_reg   <= hd_q;
                    prev_reg  <= chtir_pkg::EMPTY_LINK;
                    steps_reg <= '0;
                    state_reg <= S_SR_NRD;
                end
                S_SR_NRD:
                begin
                    if (cur_reg >= chtir_pkg::EMPTY_LINK
                        || steps_reg >= LW'(chtir_pkg::NODE_COUNT))
                    begin
                        if (!tbl_reg && mig_reg)
                        begin
                            tbl_reg   <= 1'b1;
                            state_reg <= S_SR_HD;
                        end
                        else
                            state_reg <= S_RESP;
                    end
                    else
                        state_reg <= S_SR_CMP;
                end
                S_SR_CMP:
                begin
                    if (node_hash == hash_reg && node_key == key_reg)
                    begin
                        found_reg <= 1'b1;
                        res_reg   <= cur_reg[SW-1:0];
                        if (op_reg == chtir_pkg::OP_REMOVE)
                        begin
                            if (tbl_reg)
                                new_cnt_reg <= cnt_down(new_cnt_reg);
                            else
                                old_cnt_reg <= cnt_down(old_cnt_reg);
                            state_reg <= S_SR_RM2;
                        end
                        else
                            state_reg <= S_RESP;
                    end
                    else
                    begin
                        prev_reg  <= cur_reg;
                        cur_reg   <= lk_q;
                        steps_reg <= steps_reg + LW'(1);
                        state_reg <= S_SR_NRD;
                    end
                end
                S_SR_RM2:
                begin
                    state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    done_reg      <= 1'b1;
                    out_found_reg <= found_reg;
                    out_slot_reg  <= res_reg;
                    out_cnt_reg   <= (total > (CW+1)'(chtir_pkg::NODE_COUNT))
                                     ? CW'(chtir_pkg::NODE_COUNT) : total[CW-1:0];
                    out_mig_reg   <= mig_reg;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign found         = out_found_reg;
    assign result_slot   = out_slot_reg;
    assign entry_count   = out_cnt_reg;
    assign rehash_active = out_mig_reg;

    a_mig_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        mig_reg |-> log2_reg != '0)
        else $error("rehash running on an unallocated table");

    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_RESP))
        else $error("done strobe without a response step");

    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        old_cnt_reg <= CW'(chtir_pkg::NODE_COUNT)
        && new_cnt_reg <= CW'(chtir_pkg::NODE_COUNT))
        else $error("table count above pool size");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("done strobe while a request is still in work");

endmodule
